### hdl/scba_pkg.sv
// Shared types, constants and class tables of the size-class block allocator.
package scba_pkg;

	localparam int unsigned CLASS_COUNT = 16;
	localparam int unsigned ADDR_W      = 18;
	localparam int unsigned WORD_AW     = 15;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_TOO_LARGE = 2'd1;
	localparam logic [1:0] STAT_NO_PAGE   = 2'd2;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic [4:0] CLASS_NONE = 5'd16;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_FREE_CHK,
		ST_POP_UPD,
		ST_CARVE_BASE,
		ST_CARVE_HDR,
		ST_CARVE_PUSH,
		ST_SPREAD
	} scba_state_t;

	typedef struct packed {
		logic                 we;
		logic [WORD_AW-1:0]   addr;
		logic [ADDR_W-1:0]    wdata;
	} scba_mem_req_t;

	function automatic logic [11:0] class_bytes(input logic [3:0] k);
		logic [11:0] b;
		case (k)
			4'd0:    b = 12'd16;
			4'd1:    b = 12'd24;
			4'd2:    b = 12'd32;
			4'd3:    b = 12'd48;
			4'd4:    b = 12'd64;
			4'd5:    b = 12'd96;
			4'd6:    b = 12'd128;
			4'd7:    b = 12'd192;
			4'd8:    b = 12'd256;
			4'd9:    b = 12'd384;
			4'd10:   b = 12'd512;
			4'd11:   b = 12'd768;
			4'd12:   b = 12'd1024;
			4'd13:   b = 12'd1536;
			4'd14:   b = 12'd2048;
			default: b = 12'd3072;
		endcase
		return b;
	endfunction

	// blocks pushed onto the free list when a fresh page is carved
	function automatic logic [7:0] carve_count(input logic [3:0] k);
		logic [7:0] n;
		case (k)
			4'd0:    n = 8'd254;
			4'd1:    n = 8'd169;
			4'd2:    n = 8'd126;
			4'd3:    n = 8'd84;
			4'd4:    n = 8'd62;
			4'd5:    n = 8'd41;
			4'd6:    n = 8'd30;
			4'd7:    n = 8'd20;
			4'd8:    n = 8'd14;
			4'd9:    n = 8'd9;
			4'd10:   n = 8'd6;
			4'd11:   n = 8'd4;
			4'd12:   n = 8'd2;
			4'd13:   n = 8'd1;
			default: n = 8'd0;
		endcase
		return n;
	endfunction

	// bytes left at the end of a carved page
	function automatic logic [11:0] carve_rest(input logic [3:0] k);
		logic [11:0] r;
		case (k)
			4'd0, 4'd1, 4'd3:        r = 12'd8;
			4'd2:                    r = 12'd24;
			4'd4, 4'd5, 4'd7:        r = 12'd56;
			4'd6:                    r = 12'd120;
			4'd8, 4'd9, 4'd11:       r = 12'd248;
			4'd10:                   r = 12'd504;
			4'd14:                   r = 12'd2040;
			default:                 r = 12'd1016;
		endcase
		return r;
	endfunction

	// smallest class holding n bytes, CLASS_NONE if none
	function automatic logic [4:0] fit_class(input logic [16:0] n);
		logic [4:0] c;
		c = CLASS_NONE;
		for (int k = CLASS_COUNT - 1; k >= 0; k--) begin
			if (n <= {5'd0, class_bytes(4'(k))}) begin
				c = 5'(k);
			end
		end
		return c;
	endfunction

endpackage

### hdl/size_class_block_allocator_unit.sv
// Top level of the size-class block allocator: sequencer, list heads and page counter.
//
// Usage: drive kind, request_bytes and free_address and raise start while busy is low;
// the transaction is taken at that edge and busy rises the next cycle. One result
// transaction follows per request: done is high for exactly one cycle with
// block_address, size_class and status valid. The receiver cannot stall; capture the
// result in the done cycle. busy drops in that same cycle, so a new request may start
// alongside done.
// Sequencer states per path, from the accepting edge to done, all through
// one shared header-word memory port (one access per cycle):
//   reject at decode (too large, header at zero, no page left): DECODE
//   free, or free of a header word holding 16 or more:          DECODE, FREE_CHK
//   allocate from its own list:                                 DECODE, POP_UPD
//   split of a larger block:  DECODE, POP_UPD, then a SPREAD push per remainder block
//   fresh page carve:  DECODE, CARVE_BASE, CARVE_HDR, carve_count(class) CARVE_PUSH
//                      pushes, then a SPREAD push per remainder block
// Each push is one memory write and one list-head update. Reset clears the
// sixteen list heads and the page counter; the header-word memory is not cleared,
// and every word is written before it is read in legal use.
module size_class_block_allocator_unit #(
	parameter int unsigned HEAP_PAGES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [15:0] request_bytes,
	input  logic [17:0] free_address,
	output logic        done,
	output logic [17:0] block_address,
	output logic [3:0]  size_class,
	output logic [1:0]  status
);

	// pages beyond 64 fall outside the 18-bit heap address
	localparam int unsigned PAGE_LIMIT_I = (HEAP_PAGES > 64) ? 64 : HEAP_PAGES;
	localparam logic [6:0]  PAGE_LIMIT   = 7'(PAGE_LIMIT_I);

	scba_pkg::scba_state_t state_q, state_d;

	logic        kind_q;
	logic [16:0] need_q;
	logic [17:0] faddr_q;
	logic [3:0]  cls_q, cls_d;
	logic [3:0]  src_q, src_d;
	logic [17:0] work_q, work_d;
	logic [11:0] rest_q, rest_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [17:0] res_addr_q, res_addr_d;
	logic [6:0]  pages_q, pages_d;

	logic [17:0] head_q [scba_pkg::CLASS_COUNT];
	logic [15:0] nonempty_q;

	logic        head_we;
	logic [3:0]  head_widx;
	logic [17:0] head_wdata;
	logic [3:0]  head_ridx;
	logic [17:0] head_rd;

	scba_pkg::scba_mem_req_t mreq;
	logic [17:0] mem_rdata;

	logic        fin;
	logic [17:0] fin_addr;
	logic [3:0]  fin_cls;
	logic [1:0]  fin_stat;

	logic        done_q;
	logic [17:0] out_addr_q;
	logic [3:0]  out_cls_q;
	logic [1:0]  out_stat_q;

	// scratch values of the sequencer
	logic [4:0]  fit_c;
	logic        src_found;
	logic [3:0]  src_sel;
	logic [17:0] free_hdr;
	logic [4:0]  spread_k;
	logic [3:0]  spread_cls;
	logic [17:0] page_base;

	scba_word_mem u_mem (
		.clk   (clk),
		.req   (mreq),
		.rdata (mem_rdata)
	);

	assign head_rd   = head_q[head_ridx];
	assign free_hdr  = (faddr_q - 18'd8) & ~18'd7;
	assign fit_c     = scba_pkg::fit_class(need_q);
	assign spread_k  = scba_pkg::fit_class({5'd0, rest_q});
	assign spread_cls = 4'(spread_k - 5'd1);
	assign page_base = {pages_q[5:0], 12'd0};

	// first non-empty class at or above the fitting class
	always_comb begin
		src_found = 1'b0;
		src_sel   = '0;
		for (int i = scba_pkg::CLASS_COUNT - 1; i >= 0; i--) begin
			if (nonempty_q[i] && (5'(i) >= fit_c)) begin
				src_found = 1'b1;
				src_sel   = 4'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scba_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cls_d      = cls_q;
		src_d      = src_q;
		work_d     = work_q;
		rest_d     = rest_q;
		cnt_d      = cnt_q;
		res_addr_d = res_addr_q;
		pages_d    = pages_q;
		head_we    = 1'b0;
		head_widx  = '0;
		head_wdata = '0;
		head_ridx  = '0;
		mreq       = '0;
		fin        = 1'b0;
		fin_addr   = '0;
		fin_cls    = '0;
		fin_stat   = scba_pkg::STAT_OK;
		case (state_q)
			scba_pkg::ST_IDLE: begin
				if (start) begin
					state_d = scba_pkg::ST_DECODE;
				end
			end
			scba_pkg::ST_DECODE: begin
				if (kind_q == scba_pkg::KIND_FREE) begin
					if (free_hdr == '0) begin
						fin      = 1'b1;
						fin_stat = scba_pkg::STAT_TOO_LARGE;
						state_d  = scba_pkg::ST_IDLE;
					end else begin
						mreq.addr = free_hdr[17:3];
						work_d    = free_hdr;
						state_d   = scba_pkg::ST_FREE_CHK;
					end
				end else if (fit_c == scba_pkg::CLASS_NONE) begin
					fin      = 1'b1;
					fin_stat = scba_pkg::STAT_TOO_LARGE;
					state_d  = scba_pkg::ST_IDLE;
				end else if (src_found) begin
					// pop the head of the source list; its link comes back next cycle
					head_ridx = src_sel;
					mreq.addr = head_rd[17:3];
					work_d    = head_rd;
					cls_d     = fit_c[3:0];
					src_d     = src_sel;
					state_d   = scba_pkg::ST_POP_UPD;
				end else if (pages_q >= PAGE_LIMIT) begin
					fin      = 1'b1;
					fin_stat = scba_pkg::STAT_NO_PAGE;
					state_d  = scba_pkg::ST_IDLE;
				end else begin
					cls_d   = fit_c[3:0];
					state_d = scba_pkg::ST_CARVE_BASE;
				end
			end
			scba_pkg::ST_FREE_CHK: begin
				state_d = scba_pkg::ST_IDLE;
				fin     = 1'b1;
				if (mem_rdata >= 18'd16) begin
					fin_stat = scba_pkg::STAT_TOO_LARGE;
				end else begin
					head_ridx  = mem_rdata[3:0];
					mreq.we    = 1'b1;
					mreq.addr  = work_q[17:3];
					mreq.wdata = head_rd;
					head_we    = 1'b1;
					head_widx  = mem_rdata[3:0];
					head_wdata = work_q;
					fin_cls    = mem_rdata[3:0];
				end
			end
			scba_pkg::ST_POP_UPD: begin
				head_we    = 1'b1;
				head_widx  = src_q;
				head_wdata = mem_rdata;
				mreq.we    = 1'b1;
				mreq.addr  = work_q[17:3];
				mreq.wdata = {14'd0, cls_q};
				res_addr_d = work_q + 18'd8;
				if (src_q == cls_q) begin
					fin      = 1'b1;
					fin_addr = work_q + 18'd8;
					fin_cls  = cls_q;
					state_d  = scba_pkg::ST_IDLE;
				end else begin
					work_d  = work_q + {6'd0, scba_pkg::class_bytes(cls_q)};
					rest_d  = scba_pkg::class_bytes(src_q) - scba_pkg::class_bytes(cls_q);
					state_d = scba_pkg::ST_SPREAD;
				end
			end
			scba_pkg::ST_CARVE_BASE: begin
				// zero the reserved link word of the fresh page
				mreq.we    = 1'b1;
				mreq.addr  = page_base[17:3];
				pages_d    = pages_q + 7'd1;
				work_d     = page_base + 18'd8;
				res_addr_d = page_base + 18'd16;
				state_d    = scba_pkg::ST_CARVE_HDR;
			end
			scba_pkg::ST_CARVE_HDR: begin
				mreq.we    = 1'b1;
				mreq.addr  = work_q[17:3];
				mreq.wdata = {14'd0, cls_q};
				work_d     = work_q + {6'd0, scba_pkg::class_bytes(cls_q)};
				cnt_d      = scba_pkg::carve_count(cls_q);
				rest_d     = scba_pkg::carve_rest(cls_q);
				if (scba_pkg::carve_count(cls_q) == 8'd0) begin
					state_d = scba_pkg::ST_SPREAD;
				end else begin
					state_d = scba_pkg::ST_CARVE_PUSH;
				end
			end
			scba_pkg::ST_CARVE_PUSH: begin
				head_ridx  = cls_q;
				mreq.we    = 1'b1;
				mreq.addr  = work_q[17:3];
				mreq.wdata = head_rd;
				head_we    = 1'b1;
				head_widx  = cls_q;
				head_wdata = work_q;
				work_d     = work_q + {6'd0, scba_pkg::class_bytes(cls_q)};
				cnt_d      = cnt_q - 8'd1;
				if (cnt_q == 8'd1) begin
					state_d = scba_pkg::ST_SPREAD;
				end
			end
			scba_pkg::ST_SPREAD: begin
				if ((spread_k == scba_pkg::CLASS_NONE) || (spread_k == 5'd0)) begin
					fin      = 1'b1;
					fin_addr = res_addr_q;
					fin_cls  = cls_q;
					state_d  = scba_pkg::ST_IDLE;
				end else begin
					// push onto the class strictly below the fitting one
					head_ridx  = spread_cls;
					mreq.we    = 1'b1;
					mreq.addr  = work_q[17:3];
					mreq.wdata = head_rd;
					head_we    = 1'b1;
					head_widx  = spread_cls;
					head_wdata = work_q;
					work_d     = work_q + {6'd0, scba_pkg::class_bytes(spread_cls)};
					rest_d     = rest_q - scba_pkg::class_bytes(spread_cls);
				end
			end
			default: begin
				state_d = scba_pkg::ST_IDLE;
			end
		endcase
	end

	// request capture and datapath registers
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_q  <= kind;
			need_q  <= {1'b0, request_bytes} + 17'd8;
			faddr_q <= free_address;
		end
		cls_q      <= cls_d;
		src_q      <= src_d;
		work_q     <= work_d;
		rest_q     <= rest_d;
		cnt_q      <= cnt_d;
		res_addr_q <= res_addr_d;
		if (fin) begin
			out_addr_q <= fin_addr;
			out_cls_q  <= fin_cls;
			out_stat_q <= fin_stat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pages_q    <= '0;
			nonempty_q <= '0;
			done_q     <= 1'b0;
			for (int i = 0; i < scba_pkg::CLASS_COUNT; i++) begin
				head_q[i] <= '0;
			end
		end else begin
			pages_q <= pages_d;
			done_q  <= fin;
			if (head_we) begin
				head_q[head_widx]     <= head_wdata;
				nonempty_q[head_widx] <= (head_wdata != '0);
			end
		end
	end

	assign busy          = (state_q != scba_pkg::ST_IDLE);
	assign done          = done_q;
	assign block_address = out_addr_q;
	assign size_class    = out_cls_q;
	assign status        = out_stat_q;

`ifndef NO_ASSERTIONS
	a_done_follows_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without a request in flight");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted request did not start");

	a_fail_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != scba_pkg::STAT_OK)) |-> ((block_address == '0) && (size_class == '0)))
		else $error("failed result carries an address or class");

	a_page_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pages_q <= PAGE_LIMIT) else $error("page counter past the heap limit");

	a_nonempty_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == scba_pkg::ST_POP_UPD) |-> (nonempty_q[src_q] && (head_q[src_q] != '0)))
		else $error("list flag out of step with head");
`endif

endmodule

### hdl/scba_word_mem.sv
// Block header word memory: one word per 8 heap bytes, single port, registered read.
module scba_word_mem (
	input  logic                       clk,
	input  scba_pkg::scba_mem_req_t    req,
	output logic [scba_pkg::ADDR_W-1:0] rdata
);

	logic [scba_pkg::ADDR_W-1:0] mem [2**scba_pkg::WORD_AW];
	logic [scba_pkg::ADDR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rdata_q <= mem[req.addr];
	end

	assign rdata = rdata_q;

endmodule

### tb/size_class_block_allocator_unit_test.sv
// Testbench of the size-class block allocator: directed and random requests checked against a predictor.
module size_class_block_allocator_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PAGE_LIMIT  = 64;
	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam logic [17:0] ADDR_MASK   = 18'h3FFFF;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        kind;
	logic [15:0] request_bytes;
	logic [17:0] free_address;
	logic        done;
	logic [17:0] block_address;
	logic [3:0]  size_class;
	logic [1:0]  status;

	size_class_block_allocator_unit #(.HEAP_PAGES(64)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.request_bytes(request_bytes), .free_address(free_address), .done(done),
		.block_address(block_address), .size_class(size_class), .status(status)
	);

	typedef struct {
		logic [17:0] addr;
		logic [3:0]  cls;
		logic [1:0]  st;
	} grant_t;

	// Predictor state: a private copy of the list heads, page counter and header words.
	logic [17:0] mirror_heads [scba_pkg::CLASS_COUNT];
	int unsigned mirror_pages;
	logic [17:0] mirror_words [32768];
	bit          mirror_written [32768];

	grant_t      pending_grants [$];
	logic [17:0] live_blocks [$];
	logic [17:0] freed_blocks [$];
	int unsigned mismatch_count;
	int unsigned cycle_count;
	bit          no_idle;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int unsigned size_of(input int unsigned k);
		int unsigned sizes [16] = '{16, 24, 32, 48, 64, 96, 128, 192, 256, 384, 512, 768,
			1024, 1536, 2048, 3072};
		return sizes[k];
	endfunction

	// smallest class holding n bytes, CLASS_COUNT if none fits
	function automatic int unsigned fitting_class(input int unsigned n);
		for (int unsigned k = 0; k < scba_pkg::CLASS_COUNT; k++) begin
			if (n <= size_of(k)) begin
				return k;
			end
		end
		return scba_pkg::CLASS_COUNT;
	endfunction

	function automatic void push_free(input int unsigned c, input logic [17:0] a);
		mirror_words[a[17:3]]   = mirror_heads[c];
		mirror_written[a[17:3]] = 1'b1;
		mirror_heads[c]         = a;
	endfunction

	// hand leftovers to the class strictly below the one that would hold them
	function automatic void spread_leftover(input logic [17:0] a, input int unsigned rest);
		int unsigned k;
		forever begin
			k = fitting_class(rest);
			if (k == scba_pkg::CLASS_COUNT || k == 0) begin
				return;
			end
			k--;
			push_free(k, a);
			a    = (a + 18'(size_of(k))) & ADDR_MASK;
			rest = rest - size_of(k);
		end
	endfunction

	function automatic grant_t predict_grant(input logic k, input logic [15:0] req,
		input logic [17:0] fa);
		grant_t      g;
		logic [17:0] hdr;
		logic [17:0] id;
		logic [17:0] work;
		int unsigned c;
		int unsigned cnt;
		bit          found;
		g = '{addr: '0, cls: '0, st: scba_pkg::STAT_OK};
		if (k == scba_pkg::KIND_FREE) begin
			hdr = ((fa - 18'd8) & ADDR_MASK) & ~18'd7;
			id  = (hdr != 0) ? mirror_words[hdr[17:3]] : 18'd16;
			if (id >= 16) begin
				g.st = scba_pkg::STAT_TOO_LARGE;
			end else begin
				push_free(id, hdr);
				g.cls = id[3:0];
			end
			return g;
		end
		c = fitting_class(int'(req) + 8);
		if (c == scba_pkg::CLASS_COUNT) begin
			g.st = scba_pkg::STAT_TOO_LARGE;
			return g;
		end
		if (mirror_heads[c] != 0) begin
			hdr = mirror_heads[c];
			mirror_heads[c] = mirror_words[hdr[17:3]];
			mirror_words[hdr[17:3]] = 18'(c);
			g.addr = hdr + 18'd8;
			g.cls  = c[3:0];
			return g;
		end
		found = 1'b0;
		for (int unsigned i = c + 1; i < scba_pkg::CLASS_COUNT && !found; i++) begin
			if (mirror_heads[i] != 0) begin
				hdr = mirror_heads[i];
				mirror_heads[i] = mirror_words[hdr[17:3]];
				mirror_words[hdr[17:3]] = 18'(c);
				spread_leftover((hdr + 18'(size_of(c))) & ADDR_MASK, size_of(i) - size_of(c));
				g.addr = hdr + 18'd8;
				g.cls  = c[3:0];
				found  = 1'b1;
			end
		end
		if (found) begin
			return g;
		end
		if (mirror_pages >= PAGE_LIMIT) begin
			g.st = scba_pkg::STAT_NO_PAGE;
			return g;
		end
		// carve a fresh page: reserved link word, granted header, then the rest of the class
		hdr = 18'(mirror_pages * 4096 + 8);
		cnt = (4096 - 8) / size_of(c) - 1;
		mirror_words[hdr[17:3] - 1]   = '0;
		mirror_written[hdr[17:3] - 1] = 1'b1;
		mirror_words[hdr[17:3]]       = 18'(c);
		mirror_written[hdr[17:3]]     = 1'b1;
		mirror_pages++;
		work = hdr + 18'(size_of(c));
		for (int unsigned n = 0; n < cnt; n++) begin
			push_free(c, work);
			work = work + 18'(size_of(c));
		end
		spread_leftover(work & ADDR_MASK, 4096 - (cnt + 1) * size_of(c) - 8);
		g.addr = hdr + 18'd8;
		g.cls  = c[3:0];
		return g;
	endfunction

	// Drive one transaction from the falling edge and hold it until the block takes it.
	task automatic send_request(input logic k, input logic [15:0] req, input logic [17:0] fa);
		grant_t g;
		@(negedge clk);
		if (!no_idle && $urandom_range(99) < 24) begin
			start = 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		kind          = k;
		request_bytes = req;
		free_address  = fa;
		start         = 1'b1;
		do @(posedge clk); while (busy);
		g = predict_grant(k, req, fa);
		pending_grants.push_back(g);
		if (k == scba_pkg::KIND_ALLOC && g.st == scba_pkg::STAT_OK) begin
			live_blocks.push_back(g.addr);
		end
	endtask

	task automatic alloc_bytes(input logic [15:0] req);
		send_request(scba_pkg::KIND_ALLOC, req, 18'($urandom));
	endtask

	// free a live block (or allocate when none is live), sometimes with an unaligned address within its first word
	task automatic free_live();
		int unsigned i;
		logic [17:0] a;
		if (live_blocks.size() == 0) begin
			alloc_bytes(16'($urandom_range(200)));
			return;
		end
		i = $urandom_range(live_blocks.size() - 1);
		a = live_blocks[i];
		live_blocks.delete(i);
		freed_blocks.push_back(a);
		send_request(scba_pkg::KIND_FREE, 16'($urandom), a + 18'($urandom_range(7)));
	endtask

	// double, foreign or invalid free; only words that hold a written value are read
	task automatic free_noise();
		logic [17:0] a;
		logic [17:0] hdr;
		case ($urandom_range(2))
			0: begin
				if (freed_blocks.size() > 0) begin
					a = freed_blocks[$urandom_range(freed_blocks.size() - 1)];
				end else begin
					a = 18'd8;
				end
			end
			1: begin
				a   = 18'($urandom);
				hdr = ((a - 18'd8) & ADDR_MASK) & ~18'd7;
				if (hdr != 0 && !mirror_written[hdr[17:3]]) begin
					a = 18'd8 + 18'($urandom_range(7));
				end
			end
			default: a = 18'd8 + 18'($urandom_range(7));
		endcase
		send_request(scba_pkg::KIND_FREE, 16'($urandom), a);
	endtask

	function automatic logic [15:0] random_size();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 40) return 16'($urandom_range(120));
		if (r < 70) return 16'($urandom_range(1000));
		if (r < 85) return 16'($urandom_range(3064, 1000));
		if (r < 93) return 16'($urandom_range(65535, 3065));
		return 16'($urandom);
	endfunction

	// Compare each result transaction with the oldest prediction.
	always @(posedge clk) begin
		grant_t g;
		if (arst_n && done) begin
			if (pending_grants.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("unexpected result: addr %h class %0d status %0d",
						block_address, size_class, status);
				end
			end else begin
				g = pending_grants.pop_front();
				if (block_address !== g.addr || size_class !== g.cls || status !== g.st) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch: expected addr %h class %0d status %0d, got %h %0d %0d",
							g.addr, g.cls, g.st, block_address, size_class, status);
					end
				end
			end
		end
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** size_class_block_allocator_unit: FAILED **");
			$finish;
		end
	end

	task automatic test_reset();
		for (int k = 0; k < scba_pkg::CLASS_COUNT; k++) mirror_heads[k] = '0;
		mirror_pages = 0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	endtask

	// size extremes, class boundaries, list pops, splits and rejected requests
	task automatic test_directed_alloc();
		alloc_bytes(16'd0);
		alloc_bytes(16'd8);
		alloc_bytes(16'd9);
		alloc_bytes(16'd3064);
		alloc_bytes(16'd3065);
		alloc_bytes(16'hFFFF);
		alloc_bytes(16'd120);
		alloc_bytes(16'd2040);
		alloc_bytes(16'd3064);
	endtask

	// aligned and unaligned frees, reuse, double free and header-zero frees
	task automatic test_directed_free();
		logic [17:0] a;
		a = live_blocks.pop_front();
		send_request(scba_pkg::KIND_FREE, 16'hFFFF, a + 18'd5);
		alloc_bytes(16'd4);
		send_request(scba_pkg::KIND_FREE, 16'd0, a);
		send_request(scba_pkg::KIND_FREE, 16'd0, a);
		send_request(scba_pkg::KIND_FREE, 16'd0, 18'd8);
		send_request(scba_pkg::KIND_FREE, 16'd0, 18'd15);
		a = live_blocks.pop_back();
		send_request(scba_pkg::KIND_FREE, 16'd0, a);
		alloc_bytes(16'd200);
	endtask

	// mostly allocate/free traffic, with noise and a stretch with no idle gaps
	task automatic test_random_traffic();
		int unsigned r;
		for (int n = 0; n < 800; n++) begin
			no_idle = (n >= 300 && n < 420);
			r = $urandom_range(99);
			if (r < 52) alloc_bytes(random_size());
			else if (r < 87) free_live();
			else free_noise();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		start = 1'b0;
		kind = scba_pkg::KIND_ALLOC;
		request_bytes = '0;
		free_address = '0;
		arst_n = 1'b0;
		mismatch_count = 0;
		cycle_count = 0;
		no_idle = 1'b0;
		foreach (mirror_written[i]) mirror_written[i] = 1'b0;
		test_reset();
		test_directed_alloc();
		test_directed_free();
		test_random_traffic();
		@(negedge clk);
		start = 1'b0;
		// drain, then allow for a full page carve of trailing activity
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("** size_class_block_allocator_unit: PASSED **");
		end else begin
			$display("** size_class_block_allocator_unit: FAILED **");
		end
		$finish;
	end

endmodule
